// File: rtl/sgfe_pkg.sv
// ----------------------------------------------------------------------------
// sgfe_pkg
// Shared constants, types and helper functions for the spin glass field and
// energy engine.
// ----------------------------------------------------------------------------
package sgfe_pkg;

  localparam int MAX_SPINS = 64;
  localparam int SIDX_W    = $clog2(MAX_SPINS);
  localparam int CNT_W     = $clog2(MAX_SPINS + 1);
  localparam int CPL_AW    = 2 * SIDX_W;
  localparam int CPL_DEPTH = 1 << CPL_AW;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 6;
  localparam int VAL_W    = 16;
  localparam int CFG_W    = 7;
  localparam int FIELD_W  = 37;
  localparam int PREF_W   = 2;
  localparam int ENERGY_W = 42;

  localparam int SHR     = 14;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SHPR_W  = PROD_W - SHR;
  localparam int TERM_W  = SHPR_W + VAL_W;
  localparam int ACC_W   = (TERM_W + 2 * SIDX_W > 43) ? TERM_W + 2 * SIDX_W : 43;

  localparam logic [CFG_W-1:0] SPIN_COUNT_RST = CFG_W'(64);

  localparam logic signed [VAL_W-1:0] SPIN_ONE   = 16'sd16384;
  localparam logic signed [ACC_W-1:0] FIELD_LIM  = ACC_W'(64'sd34359738368);
  localparam logic signed [ACC_W-1:0] ENERGY_LIM = ACC_W'(64'sd1099511627776);

  localparam logic signed [PREF_W-1:0] PREF_NEG  = -2'sd1;
  localparam logic signed [PREF_W-1:0] PREF_POS  = 2'sd1;
  localparam logic signed [PREF_W-1:0] PREF_ZERO = 2'sd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPIN   = 2'd0,
    KIND_CPL    = 2'd1,
    KIND_FIELD  = 2'd2,
    KIND_ENERGY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic energy;
  } mac_ctl_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] x);
    return int'(x) < MAX_SPINS;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] c);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (int'(c) > MAX_SPINS) begin
      return CNT_W'(MAX_SPINS);
    end else begin
      return CNT_W'(c);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_spin(input logic signed [VAL_W-1:0] v);
    if (v > SPIN_ONE) begin
      return SPIN_ONE;
    end else if (v < -SPIN_ONE) begin
      return -SPIN_ONE;
    end else begin
      return v;
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v,
                                                       input logic signed [ACC_W-1:0] lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end else begin
      return v;
    end
  endfunction

endpackage

// File: rtl/sgfe_in_if.sv
// ----------------------------------------------------------------------------
// sgfe_in_if
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface sgfe_in_if;
  logic                               valid;
  logic                               ready;
  logic [sgfe_pkg::KIND_W-1:0]        kind;
  logic [sgfe_pkg::IDX_W-1:0]         index_a;
  logic [sgfe_pkg::IDX_W-1:0]         index_b;
  logic signed [sgfe_pkg::VAL_W-1:0]  value;

  modport source (output valid, kind, index_a, index_b, value, input ready);
  modport sink   (input valid, kind, index_a, index_b, value, output ready);
endinterface

// File: rtl/sgfe_out_if.sv
// ----------------------------------------------------------------------------
// sgfe_out_if
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface sgfe_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sgfe_pkg::FIELD_W-1:0]   field;
  logic signed [sgfe_pkg::PREF_W-1:0]    preferred_spin;
  logic signed [sgfe_pkg::ENERGY_W-1:0]  energy;

  modport source (output valid, field, preferred_spin, energy, input ready);
  modport sink   (input valid, field, preferred_spin, energy, output ready);
endinterface

// File: rtl/sgfe_spin_ram.sv
// ----------------------------------------------------------------------------
// sgfe_spin_ram
// Spin vector memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sgfe_spin_ram (
  input  logic                               clk,
  input  logic                               we,
  input  logic [sgfe_pkg::SIDX_W-1:0]        waddr,
  input  logic signed [sgfe_pkg::VAL_W-1:0]  wdata,
  input  logic [sgfe_pkg::SIDX_W-1:0]        raddr_a,
  input  logic [sgfe_pkg::SIDX_W-1:0]        raddr_b,
  output logic signed [sgfe_pkg::VAL_W-1:0]  rdata_a,
  output logic signed [sgfe_pkg::VAL_W-1:0]  rdata_b
);

  logic signed [sgfe_pkg::VAL_W-1:0] mem [sgfe_pkg::MAX_SPINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/sgfe_cpl_ram.sv
// ----------------------------------------------------------------------------
// sgfe_cpl_ram
// Coupling matrix memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgfe_cpl_ram (
  input  logic                               clk,
  input  logic                               we,
  input  logic [sgfe_pkg::CPL_AW-1:0]        waddr,
  input  logic signed [sgfe_pkg::VAL_W-1:0]  wdata,
  input  logic [sgfe_pkg::CPL_AW-1:0]        raddr,
  output logic signed [sgfe_pkg::VAL_W-1:0]  rdata
);

  logic signed [sgfe_pkg::VAL_W-1:0] mem [sgfe_pkg::CPL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sgfe_mac.sv
// ----------------------------------------------------------------------------
// sgfe_mac
// Three-stage multiply-accumulate datapath: spin product, floored shift
// times coupling, and the running sum.
// ----------------------------------------------------------------------------
module sgfe_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sgfe_pkg::mac_ctl_t                 ctl,
  input  logic signed [sgfe_pkg::VAL_W-1:0]  spin_j,
  input  logic signed [sgfe_pkg::VAL_W-1:0]  spin_i,
  input  logic signed [sgfe_pkg::VAL_W-1:0]  cpl,
  output logic                               busy,
  output logic signed [sgfe_pkg::ACC_W-1:0]  acc
);

  logic                                  v1_r, v2_r, v3_r;
  logic signed [sgfe_pkg::PROD_W-1:0]    m1_r, m1_nxt;
  logic signed [sgfe_pkg::VAL_W-1:0]     cpl_d_r;
  logic signed [sgfe_pkg::VAL_W-1:0]     mult_b;
  logic signed [sgfe_pkg::SHPR_W-1:0]    shifted;
  logic signed [sgfe_pkg::TERM_W-1:0]    m2_r, m2_nxt;
  logic signed [sgfe_pkg::ACC_W-1:0]     acc_r, acc_nxt;

  // A field term uses the spin scaled by one so that the shift returns it.
  always_comb begin
    mult_b  = ctl.energy ? spin_i : sgfe_pkg::SPIN_ONE;
    m1_nxt  = spin_j * mult_b;
    shifted = m1_r[sgfe_pkg::PROD_W-1:sgfe_pkg::SHR];
    m2_nxt  = shifted * cpl_d_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (v3_r) begin
      acc_nxt = acc_r + sgfe_pkg::ACC_W'(m2_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= m1_nxt;
    cpl_d_r <= cpl;
    m2_r    <= m2_nxt;
    acc_r   <= acc_nxt;
  end

  assign busy = v1_r | v2_r | v3_r;
  assign acc  = acc_r;

endmodule

// File: rtl/spin_glass_field_energy.sv
// ----------------------------------------------------------------------------
// spin_glass_field_energy
// Spin glass local field and pair energy engine over stored spins and
// upper-triangular couplings.
// ----------------------------------------------------------------------------
// Each input transaction produces exactly one result transaction. Spin and
// coupling writes return an all-zero result. A field query makes one
// coupling-memory read per spin in use; an energy query reads one coupling
// per spin pair. The coupling memory has a single read port, and one query
// runs at a time. Reading a spin or coupling that was never written gives an
// undefined result.
module spin_glass_field_energy (
  input  logic                          clk,
  input  logic                          rst_n,
  sgfe_in_if.sink                       in_ch,
  sgfe_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [sgfe_pkg::CFG_W-1:0]    cfg_data
);

  sgfe_pkg::state_t                       state_r, state_nxt;
  logic [sgfe_pkg::CFG_W-1:0]             spin_count_r;
  logic [sgfe_pkg::CNT_W-1:0]             n_r, n_nxt;
  logic [sgfe_pkg::CNT_W-1:0]             i_r, i_nxt;
  logic [sgfe_pkg::CNT_W-1:0]             j_r, j_nxt;
  logic [sgfe_pkg::SIDX_W-1:0]            qa_r, qa_nxt;
  logic                                   energy_r, energy_nxt;

  logic                                   out_valid_r, out_valid_nxt;
  logic signed [sgfe_pkg::FIELD_W-1:0]    field_r, field_nxt;
  logic signed [sgfe_pkg::PREF_W-1:0]     pref_r, pref_nxt;
  logic signed [sgfe_pkg::ENERGY_W-1:0]   en_r, en_nxt;

  logic                                   in_acc;
  logic                                   issue;
  logic [sgfe_pkg::SIDX_W-1:0]            ix, jx;
  logic [sgfe_pkg::CPL_AW-1:0]            cpl_raddr;
  logic                                   spin_we, cpl_we;
  logic signed [sgfe_pkg::VAL_W-1:0]      spin_rd_j, spin_rd_i, cpl_rd;
  sgfe_pkg::mac_ctl_t                     ctl;
  logic                                   mac_busy;
  logic signed [sgfe_pkg::ACC_W-1:0]      acc;
  logic signed [sgfe_pkg::ACC_W-1:0]      acc_sat;

  assign in_ch.ready = (state_r == sgfe_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign issue       = (state_r == sgfe_pkg::ST_RUN) && (j_r < n_r);
  assign ix          = i_r[sgfe_pkg::SIDX_W-1:0];
  assign jx          = j_r[sgfe_pkg::SIDX_W-1:0];

  // Only the upper triangle is read, so the field query orders its pair.
  always_comb begin
    if (energy_r) begin
      cpl_raddr = {ix, jx};
    end else if (jx <= qa_r) begin
      cpl_raddr = {jx, qa_r};
    end else begin
      cpl_raddr = {qa_r, jx};
    end
  end

  sgfe_spin_ram u_spin_ram (
    .clk     (clk),
    .we      (spin_we),
    .waddr   (sgfe_pkg::SIDX_W'(in_ch.index_a)),
    .wdata   (sgfe_pkg::sat_spin(in_ch.value)),
    .raddr_a (jx),
    .raddr_b (ix),
    .rdata_a (spin_rd_j),
    .rdata_b (spin_rd_i)
  );

  sgfe_cpl_ram u_cpl_ram (
    .clk   (clk),
    .we    (cpl_we),
    .waddr ({sgfe_pkg::SIDX_W'(in_ch.index_a), sgfe_pkg::SIDX_W'(in_ch.index_b)}),
    .wdata (in_ch.value),
    .raddr (cpl_raddr),
    .rdata (cpl_rd)
  );

  sgfe_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .spin_j (spin_rd_j),
    .spin_i (spin_rd_i),
    .cpl    (cpl_rd),
    .busy   (mac_busy),
    .acc    (acc)
  );

  assign acc_sat = energy_r ? sgfe_pkg::sat_acc(acc, sgfe_pkg::ENERGY_LIM)
                            : sgfe_pkg::sat_acc(acc, sgfe_pkg::FIELD_LIM);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    qa_nxt        = qa_r;
    energy_nxt    = energy_r;
    ctl.clear     = 1'b0;
    ctl.issue     = issue;
    ctl.energy    = energy_r;
    spin_we       = 1'b0;
    cpl_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    field_nxt     = field_r;
    pref_nxt      = pref_r;
    en_nxt        = en_r;
    case (state_r)
      sgfe_pkg::ST_IDLE: begin
        if (in_acc) begin
          field_nxt = '0;
          pref_nxt  = sgfe_pkg::PREF_ZERO;
          en_nxt    = '0;
          case (sgfe_pkg::kind_t'(in_ch.kind))
            sgfe_pkg::KIND_SPIN: begin
              spin_we       = sgfe_pkg::idx_ok(in_ch.index_a);
              out_valid_nxt = 1'b1;
            end
            sgfe_pkg::KIND_CPL: begin
              cpl_we        = sgfe_pkg::idx_ok(in_ch.index_a) &&
                              sgfe_pkg::idx_ok(in_ch.index_b);
              out_valid_nxt = 1'b1;
            end
            sgfe_pkg::KIND_FIELD: begin
              if (sgfe_pkg::idx_ok(in_ch.index_a)) begin
                state_nxt  = sgfe_pkg::ST_RUN;
                energy_nxt = 1'b0;
                n_nxt      = sgfe_pkg::clamp_count(spin_count_r);
                i_nxt      = '0;
                j_nxt      = '0;
                qa_nxt     = sgfe_pkg::SIDX_W'(in_ch.index_a);
                ctl.clear  = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            sgfe_pkg::KIND_ENERGY: begin
              state_nxt  = sgfe_pkg::ST_RUN;
              energy_nxt = 1'b1;
              n_nxt      = sgfe_pkg::clamp_count(spin_count_r);
              i_nxt      = '0;
              j_nxt      = sgfe_pkg::CNT_W'(1);
              ctl.clear  = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      sgfe_pkg::ST_RUN: begin
        if (issue) begin
          if (energy_r && (j_r == n_r - sgfe_pkg::CNT_W'(1))) begin
            i_nxt = i_r + sgfe_pkg::CNT_W'(1);
            j_nxt = i_r + sgfe_pkg::CNT_W'(2);
          end else begin
            j_nxt = j_r + sgfe_pkg::CNT_W'(1);
          end
        end else if (!mac_busy) begin
          state_nxt = sgfe_pkg::ST_FIN;
        end
      end
      sgfe_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = sgfe_pkg::ST_IDLE;
          if (energy_r) begin
            field_nxt = '0;
            pref_nxt  = sgfe_pkg::PREF_ZERO;
            en_nxt    = acc_sat[sgfe_pkg::ENERGY_W-1:0];
          end else begin
            field_nxt = acc_sat[sgfe_pkg::FIELD_W-1:0];
            en_nxt    = '0;
            if (acc[sgfe_pkg::ACC_W-1]) begin
              pref_nxt = sgfe_pkg::PREF_POS;
            end else if (acc != '0) begin
              pref_nxt = sgfe_pkg::PREF_NEG;
            end else begin
              pref_nxt = sgfe_pkg::PREF_ZERO;
            end
          end
        end
      end
      default: begin
        state_nxt = sgfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sgfe_pkg::ST_IDLE;
      spin_count_r <= sgfe_pkg::SPIN_COUNT_RST;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      qa_r         <= '0;
      energy_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        spin_count_r <= cfg_data;
      end
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      qa_r        <= qa_nxt;
      energy_r    <= energy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    field_r <= field_nxt;
    pref_r  <= pref_nxt;
    en_r    <= en_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.field          = field_r;
  assign out_ch.preferred_spin = pref_r;
  assign out_ch.energy         = en_r;

`ifndef SYNTH
  a_busy_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    mac_busy |-> (state_r == sgfe_pkg::ST_RUN))
    else $error("Datapath busy outside of a query.");

  a_fin_pipeline_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgfe_pkg::ST_FIN) |-> !mac_busy)
    else $error("Result taken before the datapath drained.");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && energy_r) |-> (i_r < j_r))
    else $error("Energy pair issued outside the upper triangle.");

  a_pref_matches_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((pref_r == sgfe_pkg::PREF_ZERO) == (field_r == '0)))
    else $error("Preferred spin disagrees with the field.");

  a_pref_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pref_r != 2'b10))
    else $error("Preferred spin out of range.");
`endif

endmodule

// File: dv/tb_spin_glass_field_energy.sv
// ----------------------------------------------------------------------------
// tb_spin_glass_field_energy
// Drives load, field query and energy query transactions into the spin glass
// engine under random idling and backpressure. A scoreboard class keeps its
// own copy of the spins, couplings and spin count, predicts every result and
// checks its field, preferred spin and energy. The stimulus writes every spin
// and coupling before a query reads it.
// ----------------------------------------------------------------------------
module tb_spin_glass_field_energy;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RESET_CYCLES = 11;
  localparam int     RANDOM_ITEMS = 80;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     TAIL_CYCLES  = 100;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam longint FIELD_MAX    = 64'sd34359738368;
  localparam longint ENERGY_MAX   = 64'sd1099511627776;

  typedef struct {
    logic signed [sgfe_pkg::FIELD_W-1:0]  field;
    logic signed [sgfe_pkg::PREF_W-1:0]   pref;
    logic signed [sgfe_pkg::ENERGY_W-1:0] energy;
  } outcome_t;

  class field_energy_board;
    logic signed [sgfe_pkg::VAL_W-1:0] spins[sgfe_pkg::MAX_SPINS];
    logic signed [sgfe_pkg::VAL_W-1:0] couplings[sgfe_pkg::MAX_SPINS][sgfe_pkg::MAX_SPINS];
    int unsigned                       span;
    outcome_t                          outcomes[$];
    int                                errors;

    function void set_spin_count(logic [sgfe_pkg::CFG_W-1:0] raw);
      if (raw == '0) begin
        span = 1;
      end else if (int'(raw) > sgfe_pkg::MAX_SPINS) begin
        span = sgfe_pkg::MAX_SPINS;
      end else begin
        span = 32'(raw);
      end
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function void note_command(sgfe_pkg::kind_t k, logic [sgfe_pkg::IDX_W-1:0] a,
                               logic [sgfe_pkg::IDX_W-1:0] b,
                               logic signed [sgfe_pkg::VAL_W-1:0] v);
      outcome_t want;
      longint   acc;
      longint   prod;
      int       r;
      int       c;
      want.field  = '0;
      want.pref   = sgfe_pkg::PREF_ZERO;
      want.energy = '0;
      acc         = 0;
      case (k)
        sgfe_pkg::KIND_SPIN: begin
          if (v > 16'sd16384) begin
            spins[a] = 16'sd16384;
          end else if (v < -16'sd16384) begin
            spins[a] = -16'sd16384;
          end else begin
            spins[a] = v;
          end
        end
        sgfe_pkg::KIND_CPL: begin
          couplings[a][b] = v;
        end
        sgfe_pkg::KIND_FIELD: begin
          for (int i = 0; i < span; i++) begin
            r = (i < a) ? i : a;
            c = (i < a) ? a : i;
            acc += longint'(spins[i]) * longint'(couplings[r][c]);
          end
          want.pref = (acc > 0) ? sgfe_pkg::PREF_NEG :
                      (acc < 0) ? sgfe_pkg::PREF_POS : sgfe_pkg::PREF_ZERO;
          if (acc > FIELD_MAX) begin
            acc = FIELD_MAX;
          end else if (acc < -FIELD_MAX) begin
            acc = -FIELD_MAX;
          end
          want.field = acc[sgfe_pkg::FIELD_W-1:0];
        end
        default: begin
          for (int i = 0; i < span; i++) begin
            for (int j = i + 1; j < span; j++) begin
              prod = longint'(spins[i]) * longint'(spins[j]);
              acc += (prod >>> sgfe_pkg::SHR) * longint'(couplings[i][j]);
            end
          end
          if (acc > ENERGY_MAX) begin
            acc = ENERGY_MAX;
          end else if (acc < -ENERGY_MAX) begin
            acc = -ENERGY_MAX;
          end
          want.energy = acc[sgfe_pkg::ENERGY_W-1:0];
        end
      endcase
      outcomes.push_back(want);
    endfunction

    function void check_result(logic signed [sgfe_pkg::FIELD_W-1:0] f,
                               logic signed [sgfe_pkg::PREF_W-1:0] p,
                               logic signed [sgfe_pkg::ENERGY_W-1:0] e);
      outcome_t want;
      if (outcomes.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      want = outcomes.pop_front();
      if (f !== want.field) begin
        $error("field: expected %0d, got %0d", want.field, f);
        errors++;
      end
      if (p !== want.pref) begin
        $error("preferred_spin: expected %0d, got %0d", want.pref, p);
        errors++;
      end
      if (e !== want.energy) begin
        $error("energy: expected %0d, got %0d", want.energy, e);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [sgfe_pkg::CFG_W-1:0] cfg_data;

  sgfe_in_if  in_ch ();
  sgfe_out_if out_ch ();

  spin_glass_field_energy uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  field_energy_board board;
  bit                spin_known[sgfe_pkg::MAX_SPINS];
  bit                cpl_known[sgfe_pkg::MAX_SPINS][sgfe_pkg::MAX_SPINS];
  bit                idle_on       = 1'b1;
  int                hold_request  = 0;
  int                items_sent    = 0;
  int                active_spins  = sgfe_pkg::MAX_SPINS;
  int                cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("spin_glass_field_energy: mismatch");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.field, out_ch.preferred_spin, out_ch.energy);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 11) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic issue(sgfe_pkg::kind_t k, logic [sgfe_pkg::IDX_W-1:0] a,
                       logic [sgfe_pkg::IDX_W-1:0] b,
                       logic signed [sgfe_pkg::VAL_W-1:0] v);
    while (idle_on && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.index_a <= a;
    in_ch.index_b <= b;
    in_ch.value   <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_command(k, a, b, v);
    items_sent++;
    if (k == sgfe_pkg::KIND_SPIN) begin
      spin_known[a] = 1'b1;
    end else if (k == sgfe_pkg::KIND_CPL && a <= b) begin
      cpl_known[a][b] = 1'b1;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_spin_count(logic [sgfe_pkg::CFG_W-1:0] raw);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= raw;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_spin_count(raw);
    active_spins = board.span;
  endtask

  function automatic logic signed [sgfe_pkg::VAL_W-1:0] pick_spin();
    case ($urandom_range(9))
      0:       return 16'sd16384;
      1:       return -16'sd16384;
      2:       return '0;
      3:       return sgfe_pkg::VAL_W'($urandom);
      default: return sgfe_pkg::VAL_W'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic signed [sgfe_pkg::VAL_W-1:0] pick_coupling();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return sgfe_pkg::VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [sgfe_pkg::CFG_W-1:0] pick_count();
    case ($urandom_range(19))
      0:          return '0;
      1:          return sgfe_pkg::CFG_W'(64);
      2:          return sgfe_pkg::CFG_W'($urandom_range(65, 127));
      3, 4, 5:    return sgfe_pkg::CFG_W'($urandom_range(9, 16));
      default:    return sgfe_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic query_field(int a);
    int r;
    int c;
    for (int i = 0; i < active_spins; i++) begin
      if (!spin_known[i]) begin
        issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'(i), sgfe_pkg::IDX_W'($urandom),
              pick_spin());
      end
    end
    for (int i = 0; i < active_spins; i++) begin
      r = (i < a) ? i : a;
      c = (i < a) ? a : i;
      if (!cpl_known[r][c]) begin
        issue(sgfe_pkg::KIND_CPL, sgfe_pkg::IDX_W'(r), sgfe_pkg::IDX_W'(c),
              pick_coupling());
      end
    end
    issue(sgfe_pkg::KIND_FIELD, sgfe_pkg::IDX_W'(a), sgfe_pkg::IDX_W'($urandom),
          sgfe_pkg::VAL_W'($urandom));
  endtask

  task automatic query_energy();
    for (int i = 0; i < active_spins; i++) begin
      if (!spin_known[i]) begin
        issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'(i), sgfe_pkg::IDX_W'($urandom),
              pick_spin());
      end
    end
    for (int i = 0; i < active_spins; i++) begin
      for (int j = i + 1; j < active_spins; j++) begin
        if (!cpl_known[i][j]) begin
          issue(sgfe_pkg::KIND_CPL, sgfe_pkg::IDX_W'(i), sgfe_pkg::IDX_W'(j),
                pick_coupling());
        end
      end
    end
    issue(sgfe_pkg::KIND_ENERGY, sgfe_pkg::IDX_W'($urandom), sgfe_pkg::IDX_W'($urandom),
          sgfe_pkg::VAL_W'($urandom));
  endtask

  initial begin
    int  r;
    int  c;
    bit  hold_done;
    bit  pause_done;
    board         = new;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= '0;
    in_ch.index_a <= '0;
    in_ch.index_b <= '0;
    in_ch.value   <= '0;
    board.set_spin_count(sgfe_pkg::SPIN_COUNT_RST);
    active_spins = board.span;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Full-size field at both saturation limits, first under the reset count.
    for (int i = 0; i < sgfe_pkg::MAX_SPINS; i++) begin
      issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'(i), sgfe_pkg::IDX_W'($urandom),
            -16'sd16384);
    end
    for (int i = 0; i < sgfe_pkg::MAX_SPINS; i++) begin
      issue(sgfe_pkg::KIND_CPL, sgfe_pkg::IDX_W'(i),
            sgfe_pkg::IDX_W'(sgfe_pkg::MAX_SPINS - 1), 16'sh8000);
    end
    issue(sgfe_pkg::KIND_FIELD, sgfe_pkg::IDX_W'(sgfe_pkg::MAX_SPINS - 1), '0, '0);
    set_spin_count(sgfe_pkg::CFG_W'(127));
    for (int i = 0; i < sgfe_pkg::MAX_SPINS; i++) begin
      issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'(i), sgfe_pkg::IDX_W'($urandom),
            16'sd16384);
    end
    issue(sgfe_pkg::KIND_FIELD, sgfe_pkg::IDX_W'(sgfe_pkg::MAX_SPINS - 1), '1, '1);

    // A zero count behaves as one spin; spin writes saturate.
    set_spin_count('0);
    issue(sgfe_pkg::KIND_SPIN, '0, '0, 16'sh7fff);
    issue(sgfe_pkg::KIND_CPL, '0, '0, '0);
    issue(sgfe_pkg::KIND_FIELD, '0, '0, '0);
    issue(sgfe_pkg::KIND_ENERGY, '0, '0, '0);
    issue(sgfe_pkg::KIND_SPIN, '0, '1, 16'sh8000);
    issue(sgfe_pkg::KIND_CPL, '0, '0, 16'sh7fff);
    issue(sgfe_pkg::KIND_FIELD, '0, '1, '0);

    // Flooring shift of a negative product, then a lower-triangle write.
    set_spin_count(sgfe_pkg::CFG_W'(2));
    issue(sgfe_pkg::KIND_SPIN, '0, '0, 16'sd3);
    issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'(1), '0, -16'sd5);
    issue(sgfe_pkg::KIND_CPL, '0, sgfe_pkg::IDX_W'(1), 16'sd7);
    issue(sgfe_pkg::KIND_ENERGY, '0, '0, '0);
    query_field(1);
    issue(sgfe_pkg::KIND_CPL, sgfe_pkg::IDX_W'(1), '0, 16'sh7fff);
    issue(sgfe_pkg::KIND_ENERGY, '1, '1, '1);
    issue(sgfe_pkg::KIND_SPIN, '0, '0, -16'sd16384);
    issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'(1), '0, 16'sd16384);
    issue(sgfe_pkg::KIND_CPL, '0, sgfe_pkg::IDX_W'(1), 16'sh8000);
    issue(sgfe_pkg::KIND_ENERGY, '0, '0, '0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = !(items_sent >= 10 && items_sent < 40);
      if (!hold_done && items_sent >= 45) begin
        hold_done    = 1'b1;
        hold_request = HOLD_CYCLES;
      end
      if (!pause_done && items_sent >= 60) begin
        pause_done = 1'b1;
        drain();
      end
      r = $urandom_range(99);
      if (r < 8) begin
        set_spin_count(pick_count());
      end else if (r < 40) begin
        query_field($urandom_range(sgfe_pkg::MAX_SPINS - 1));
      end else if (r < 60) begin
        if (active_spins <= 16) begin
          query_energy();
        end else begin
          query_field($urandom_range(sgfe_pkg::MAX_SPINS - 1));
        end
      end else begin
        case ($urandom_range(2))
          0: begin
            issue(sgfe_pkg::KIND_SPIN, sgfe_pkg::IDX_W'($urandom),
                  sgfe_pkg::IDX_W'($urandom), pick_spin());
          end
          1: begin
            r = $urandom_range(active_spins - 1);
            c = $urandom_range(r, active_spins - 1);
            issue(sgfe_pkg::KIND_CPL, sgfe_pkg::IDX_W'(r), sgfe_pkg::IDX_W'(c),
                  pick_coupling());
          end
          default: begin
            issue(sgfe_pkg::KIND_CPL, sgfe_pkg::IDX_W'($urandom),
                  sgfe_pkg::IDX_W'($urandom), pick_coupling());
          end
        endcase
      end
    end

    idle_on = 1'b1;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("spin_glass_field_energy: match");
    end else begin
      $display("spin_glass_field_energy: mismatch");
    end
    $finish;
  end

endmodule
